// ----- src/dhmp_pkg.sv -----
`default_nettype none
package dhmp_pkg;

    localparam logic [31:0] FILE_MAGIC  = 32'h2053_4444;
    localparam logic [31:0] HDR_END     = 32'd128;
    localparam logic [31:0] DATA_START  = 32'd148;
    localparam logic [31:0] FLAG_MIPCNT = 32'h0002_0000;
    localparam logic [31:0] PF_FOURCC   = 32'h0000_0004;
    localparam logic [31:0] FOURCC_DX10 = 32'h3031_5844;

    localparam logic [7:0] POS_MAGIC  = 8'd3;
    localparam logic [7:0] POS_FLAGS  = 8'd11;
    localparam logic [7:0] POS_HEIGHT = 8'd15;
    localparam logic [7:0] POS_WIDTH  = 8'd19;
    localparam logic [7:0] POS_MIPS   = 8'd31;
    localparam logic [7:0] POS_PFFLAG = 8'd83;
    localparam logic [7:0] POS_FOURCC = 8'd87;
    localparam logic [7:0] POS_HDREND = 8'd127;
    localparam logic [7:0] POS_FORMAT = 8'd131;
    localparam logic [7:0] POS_LAST   = 8'd147;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_SHORT,
        ERR_MAGIC,
        ERR_NOT_DX10,
        ERR_DX10_CUT,
        ERR_FORMAT,
        ERR_MIP_CUT,
        ERR_TOO_MANY
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_MUL,
        ST_SIZE,
        ST_CHK
    } state_t;

    // Size class of a DXGI format: block or pixel based, unit = 4 << sh bytes.
    typedef struct packed {
        logic       ok;
        logic       blk;
        logic [1:0] sh;
    } fmt_info_t;

    typedef struct packed {
        logic  take;
        logic  walk_init;
        logic  do_mul;
        logic  do_size;
        logic  advance;
        logic  load_desc;
        logic  load_err;
        logic  err_use_fmt;
        err_t  err_code;
    } cmd_t;

    typedef struct packed {
        logic short_len;
        logic magic_bad;
        logic dx10_bad;
        logic dx10_cut;
        logic at_walk;
        logic size_zero;
        logic cut;
        logic level_last;
        logic count_over;
        logic out_valid;
        logic out_busy;
    } sts_t;

    function automatic fmt_info_t fmt_decode(input logic [31:0] code);
        fmt_info_t r;
        r = '{ok: 1'b0, blk: 1'b0, sh: 2'd0};
        case (code)
            32'd71, 32'd72, 32'd80, 32'd81:
                r = '{ok: 1'b1, blk: 1'b1, sh: 2'd1};
            32'd74, 32'd75, 32'd77, 32'd78, 32'd83, 32'd84,
            32'd95, 32'd96, 32'd98, 32'd99:
                r = '{ok: 1'b1, blk: 1'b1, sh: 2'd2};
            32'd28, 32'd29:
                r = '{ok: 1'b1, blk: 1'b0, sh: 2'd0};
            32'd10:
                r = '{ok: 1'b1, blk: 1'b0, sh: 2'd1};
            32'd2:
                r = '{ok: 1'b1, blk: 1'b0, sh: 2'd2};
            default:
                r = '{ok: 1'b0, blk: 1'b0, sh: 2'd0};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/dhmp_ctrl.sv -----
`default_nettype none
module dhmp_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           start_of_file,
    output logic                in_ready,
    input  wire dhmp_pkg::sts_t sts,
    output dhmp_pkg::cmd_t      cmd
);

    dhmp_pkg::state_t state_reg, state_next;
    logic             emit_pass_reg, emit_pass_next;
    logic             accept;

    assign in_ready = ((state_reg == dhmp_pkg::ST_IDLE) || (state_reg == dhmp_pkg::ST_HDR))
                      && !sts.out_valid;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dhmp_pkg::ST_IDLE;
            emit_pass_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_pass_reg <= emit_pass_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next     = state_reg;
        emit_pass_next = emit_pass_reg;
        case (state_reg)
            dhmp_pkg::ST_IDLE, dhmp_pkg::ST_HDR:
            begin
                if (accept && (start_of_file || state_reg == dhmp_pkg::ST_HDR))
                begin
                    if (start_of_file && sts.short_len)
                        state_next = dhmp_pkg::ST_IDLE;
                    else if (sts.magic_bad || sts.dx10_bad || sts.dx10_cut)
                        state_next = dhmp_pkg::ST_IDLE;
                    else if (sts.at_walk)
                    begin
                        state_next     = dhmp_pkg::ST_MUL;
                        emit_pass_next = 1'b0;
                    end
                    else
                        state_next = dhmp_pkg::ST_HDR;
                end
            end
            dhmp_pkg::ST_MUL:  state_next = dhmp_pkg::ST_SIZE;
            dhmp_pkg::ST_SIZE: state_next = dhmp_pkg::ST_CHK;
            dhmp_pkg::ST_CHK:
            begin
                if (!emit_pass_reg)
                begin
                    if (sts.size_zero || sts.cut)
                        state_next = dhmp_pkg::ST_IDLE;
                    else if (sts.level_last && sts.count_over)
                        state_next = dhmp_pkg::ST_IDLE;
                    else
                    begin
                        state_next = dhmp_pkg::ST_MUL;
                        if (sts.level_last)
                            emit_pass_next = 1'b1;
                    end
                end
                else if (!sts.out_busy)
                    state_next = sts.level_last ? dhmp_pkg::ST_IDLE : dhmp_pkg::ST_MUL;
            end
            default: state_next = dhmp_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd = '{take: 1'b0, walk_init: 1'b0, do_mul: 1'b0, do_size: 1'b0, advance: 1'b0,
                load_desc: 1'b0, load_err: 1'b0, err_use_fmt: 1'b0,
                err_code: dhmp_pkg::ERR_NONE};
        case (state_reg)
            dhmp_pkg::ST_IDLE, dhmp_pkg::ST_HDR:
            begin
                if (accept && (start_of_file || state_reg == dhmp_pkg::ST_HDR))
                begin
                    if (start_of_file && sts.short_len)
                    begin
                        cmd.load_err = 1'b1;
                        cmd.err_code = dhmp_pkg::ERR_SHORT;
                    end
                    else
                    begin
                        cmd.take = 1'b1;
                        if (sts.magic_bad)
                        begin
                            cmd.load_err = 1'b1;
                            cmd.err_code = dhmp_pkg::ERR_MAGIC;
                        end
                        else if (sts.dx10_bad)
                        begin
                            cmd.load_err = 1'b1;
                            cmd.err_code = dhmp_pkg::ERR_NOT_DX10;
                        end
                        else if (sts.dx10_cut)
                        begin
                            cmd.load_err = 1'b1;
                            cmd.err_code = dhmp_pkg::ERR_DX10_CUT;
                        end
                        else if (sts.at_walk)
                            cmd.walk_init = 1'b1;
                    end
                end
            end
            dhmp_pkg::ST_MUL:  cmd.do_mul = 1'b1;
            dhmp_pkg::ST_SIZE: cmd.do_size = 1'b1;
            dhmp_pkg::ST_CHK:
            begin
                if (!emit_pass_reg)
                begin
                    cmd.err_use_fmt = 1'b1;
                    if (sts.size_zero)
                    begin
                        cmd.load_err = 1'b1;
                        cmd.err_code = dhmp_pkg::ERR_FORMAT;
                    end
                    else if (sts.cut)
                    begin
                        cmd.load_err = 1'b1;
                        cmd.err_code = dhmp_pkg::ERR_MIP_CUT;
                    end
                    else if (sts.level_last)
                    begin
                        if (sts.count_over)
                        begin
                            cmd.load_err = 1'b1;
                            cmd.err_code = dhmp_pkg::ERR_TOO_MANY;
                        end
                        else
                            cmd.walk_init = 1'b1;
                    end
                    else
                        cmd.advance = 1'b1;
                end
                else if (!sts.out_busy)
                begin
                    cmd.load_desc = 1'b1;
                    cmd.advance   = !sts.level_last;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- src/dhmp_dp.sv -----
`default_nettype none
module dhmp_dp #(
    parameter int MAX_MIPS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [7:0]     data_byte,
    input  wire logic           start_of_file,
    input  wire logic [31:0]    total_length,
    input  wire dhmp_pkg::cmd_t cmd,
    output dhmp_pkg::sts_t      sts,
    input  wire logic           out_ready,
    output logic                out_valid,
    output logic                kind,
    output logic [2:0]          error_code,
    output logic [3:0]          mip_index,
    output logic [31:0]         data_offset,
    output logic [31:0]         data_size,
    output logic [31:0]         mip_width,
    output logic [31:0]         mip_height,
    output logic [31:0]         pixel_format,
    output logic [4:0]          level_count,
    output logic                last
);

    localparam int LW = $clog2(MAX_MIPS + 1);

    // Header capture.
    logic [7:0]  pos_reg;
    logic [31:0] ws_reg, flen_reg, hflags_reg, bw_reg, bh_reg, mips_reg;
    logic [31:0] pfflags_reg, fourcc_reg, fmt_reg;
    logic [7:0]  pos_eff;
    logic [31:0] ws_new;

    // Walk.
    logic [31:0]   w_reg, h_reg, count_reg;
    logic [32:0]   off_reg;
    logic [LW-1:0] lvl_reg, n_reg;
    logic [63:0]   prod_reg;
    logic [36:0]   size_reg, size_next;
    logic [31:0]   mul_a, mul_b, count_new;
    logic [37:0]   end_sum;
    logic [2:0]    shamt;
    logic [31:0]   lvl_ext;
    dhmp_pkg::fmt_info_t fi;

    // Result register.
    logic                out_valid_reg;
    logic                kind_reg, last_reg;
    dhmp_pkg::err_t      err_reg;
    logic [3:0]          idx_reg;
    logic [31:0]         off_o_reg, size_o_reg, w_o_reg, h_o_reg, fmt_o_reg;
    logic [4:0]          cnt_o_reg;

    assign pos_eff = start_of_file ? 8'd0 : pos_reg;
    assign ws_new  = start_of_file ? {data_byte, 24'd0} : {data_byte, ws_reg[31:8]};
    assign fi      = dhmp_pkg::fmt_decode(fmt_reg);
    assign shamt   = {1'b0, fi.sh} + 3'd2;

    assign count_new = ((hflags_reg & dhmp_pkg::FLAG_MIPCNT) != 32'd0 && mips_reg != 32'd0)
                       ? mips_reg : 32'd1;

    assign mul_a = fi.blk ? ({2'b00, w_reg[31:2]} + {31'd0, |w_reg[1:0]}) : w_reg;
    assign mul_b = fi.blk ? ({2'b00, h_reg[31:2]} + {31'd0, |h_reg[1:0]}) : h_reg;

    always_comb
    begin
        if (!fi.ok)
            size_next = 37'd0;
        else if (prod_reg[63:32] != 32'd0)
            size_next = 37'h1_0000_0000;
        else
            size_next = {5'd0, prod_reg[31:0]} << shamt;
    end

    assign end_sum = {5'd0, off_reg} + {1'b0, size_reg};
    assign lvl_ext = 32'(lvl_reg);

    always_comb
    begin
        sts.short_len  = total_length < dhmp_pkg::HDR_END;
        sts.magic_bad  = (pos_eff == dhmp_pkg::POS_MAGIC) && (ws_new != dhmp_pkg::FILE_MAGIC);
        sts.dx10_bad   = (pos_eff == dhmp_pkg::POS_HDREND)
                         && !(((pfflags_reg & dhmp_pkg::PF_FOURCC) != 32'd0)
                              && (fourcc_reg == dhmp_pkg::FOURCC_DX10));
        sts.dx10_cut   = (pos_eff == dhmp_pkg::POS_HDREND) && (flen_reg < dhmp_pkg::DATA_START);
        sts.at_walk    = pos_eff == dhmp_pkg::POS_LAST;
        sts.size_zero  = size_reg == 37'd0;
        sts.cut        = end_sum > {6'd0, flen_reg};
        sts.level_last = (lvl_reg + LW'(1)) == n_reg;
        sts.count_over = count_reg > 32'(MAX_MIPS);
        sts.out_valid  = out_valid_reg;
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 8'd0;
            ws_reg   <= 32'd0;
            flen_reg <= 32'd0;
        end
        else if (cmd.take)
        begin
            pos_reg <= pos_eff + 8'd1;
            ws_reg  <= ws_new;
            if (start_of_file)
                flen_reg <= total_length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            case (pos_eff)
                dhmp_pkg::POS_FLAGS:  hflags_reg  <= ws_new;
                dhmp_pkg::POS_HEIGHT: bh_reg      <= ws_new;
                dhmp_pkg::POS_WIDTH:  bw_reg      <= ws_new;
                dhmp_pkg::POS_MIPS:   mips_reg    <= ws_new;
                dhmp_pkg::POS_PFFLAG: pfflags_reg <= ws_new;
                dhmp_pkg::POS_FOURCC: fourcc_reg  <= ws_new;
                dhmp_pkg::POS_FORMAT: fmt_reg     <= ws_new;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
        begin
            w_reg     <= bw_reg;
            h_reg     <= bh_reg;
            off_reg   <= {1'b0, dhmp_pkg::DATA_START};
            lvl_reg   <= '0;
            count_reg <= count_new;
            n_reg     <= (count_new > 32'(MAX_MIPS)) ? LW'(MAX_MIPS) : count_new[LW-1:0];
        end
        else if (cmd.advance)
        begin
            w_reg   <= (w_reg > 32'd1) ? (w_reg >> 1) : 32'd1;
            h_reg   <= (h_reg > 32'd1) ? (h_reg >> 1) : 32'd1;
            off_reg <= end_sum[32:0];
            lvl_reg <= lvl_reg + LW'(1);
        end
        if (cmd.do_mul)
            prod_reg <= {32'd0, mul_a} * {32'd0, mul_b};
        if (cmd.do_size)
            size_reg <= size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_desc || cmd.load_err)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_err)
        begin
            kind_reg   <= 1'b1;
            err_reg    <= cmd.err_code;
            idx_reg    <= 4'd0;
            off_o_reg  <= 32'd0;
            size_o_reg <= 32'd0;
            w_o_reg    <= 32'd0;
            h_o_reg    <= 32'd0;
            fmt_o_reg  <= cmd.err_use_fmt ? fmt_reg : 32'd0;
            cnt_o_reg  <= 5'd0;
            last_reg   <= 1'b1;
        end
        else if (cmd.load_desc)
        begin
            kind_reg   <= 1'b0;
            err_reg    <= dhmp_pkg::ERR_NONE;
            idx_reg    <= lvl_ext[3:0];
            off_o_reg  <= off_reg[31:0];
            size_o_reg <= size_reg[31:0];
            w_o_reg    <= w_reg;
            h_o_reg    <= h_reg;
            fmt_o_reg  <= fmt_reg;
            cnt_o_reg  <= count_reg[4:0];
            last_reg   <= sts.level_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign error_code   = err_reg;
    assign mip_index    = idx_reg;
    assign data_offset  = off_o_reg;
    assign data_size    = size_o_reg;
    assign mip_width    = w_o_reg;
    assign mip_height   = h_o_reg;
    assign pixel_format = fmt_o_reg;
    assign level_count  = cnt_o_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire

// ----- src/dds_header_mip_chain_parser.sv -----
// Header bytes are taken one per cycle while no result is pending; a byte that fails a
// header check yields its error report in the register on the next cycle, and the next
// byte waits until it is taken. After the last DX10 header byte (file byte 147) the mip
// walk steps each level through the shared multiplier and size/compare stages: one
// checking pass over all levels, then, if no level fails, one emitting pass.
// Asynchronous active-low reset leaves the parser idle; bytes are ignored until a start.
`default_nettype none
module dds_header_mip_chain_parser #(
    parameter int MAX_MIPS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_of_file,
    input  wire logic [31:0] total_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [2:0]       error_code,
    output logic [3:0]       mip_index,
    output logic [31:0]      data_offset,
    output logic [31:0]      data_size,
    output logic [31:0]      mip_width,
    output logic [31:0]      mip_height,
    output logic [31:0]      pixel_format,
    output logic [4:0]       level_count,
    output logic             last
);

    // The controller sequences header capture and the two-pass mip walk. The first pass
    // only checks every level, because any error must replace all descriptors; the second
    // pass recomputes each level and hands it to the result register as a transaction.
    dhmp_pkg::cmd_t cmd;
    dhmp_pkg::sts_t sts;

    dhmp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .start_of_file (start_of_file),
        .in_ready      (in_ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    // The datapath holds the header words, the walk registers (dimensions, offset,
    // level), the product and size registers, and the result register.
    dhmp_dp #(
        .MAX_MIPS (MAX_MIPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .total_length  (total_length),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .kind          (kind),
        .error_code    (error_code),
        .mip_index     (mip_index),
        .data_offset   (data_offset),
        .data_size     (data_size),
        .mip_width     (mip_width),
        .mip_height    (mip_height),
        .pixel_format  (pixel_format),
        .level_count   (level_count),
        .last          (last)
    );

    // Input is never taken while a result transaction is pending.
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while a result is pending");

    // Every error report closes the file.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind) |-> last)
        else $error("error report without last");

    // A descriptor always covers some data and lies past the DX10 header.
    a_desc_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind) |-> (data_size != 32'd0 && data_offset >= 32'd148))
        else $error("bad descriptor size or offset");

endmodule
`default_nettype wire

// ----- tb/dds_header_mip_chain_parser_test.sv -----
`default_nettype none
module dds_header_mip_chain_parser_test;

    // Kinds of result that the parser reports.
    localparam logic KIND_MIP = 1'b0;
    localparam logic KIND_ERR = 1'b1;

    // One DXGI code of each size class, plus one that the parser does not know.
    localparam logic [31:0] FMT_BC1     = 32'd71;
    localparam logic [31:0] FMT_BC3     = 32'd77;
    localparam logic [31:0] FMT_RGBA8   = 32'd28;
    localparam logic [31:0] FMT_RGBA16F = 32'd10;
    localparam logic [31:0] FMT_RGBA32F = 32'd2;
    localparam logic [31:0] FMT_UNKNOWN = 32'd55;

    localparam int HDR_BYTES   = 148;
    localparam int LEVEL_LIMIT = 16;
    localparam int WATCHDOG    = 20000;
    localparam int HOLD_CYCLES = 400;

    // One result transaction as the parser presents it.
    typedef struct packed {
        logic           kind;
        dhmp_pkg::err_t code;
        logic [3:0]     index;
        logic [31:0]    offset;
        logic [31:0]    size;
        logic [31:0]    width;
        logic [31:0]    height;
        logic [31:0]    format;
        logic [4:0]     count;
        logic           last;
    } mip_result_t;

    // One file of stimulus: the header fields, how many bytes of it are sent, and how
    // many stray bytes without a start follow it.
    typedef struct {
        logic [31:0]    length;
        logic [31:0]    magic;
        logic [31:0]    flags;
        logic [31:0]    width;
        logic [31:0]    height;
        logic [31:0]    mips;
        logic [31:0]    pf_flags;
        logic [31:0]    four_cc;
        logic [31:0]    format;
        int             nbytes;
        int             tail;
        bit             typed;
        dhmp_pkg::err_t typed_code;
        bit             hold;
    } dds_file_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        start_of_file;
    logic [31:0] total_length;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [2:0]  error_code;
    logic [3:0]  mip_index;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [31:0] mip_width;
    logic [31:0] mip_height;
    logic [31:0] pixel_format;
    logic [4:0]  level_count;
    logic        last;

    dds_header_mip_chain_parser #(.MAX_MIPS(LEVEL_LIMIT)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .start_of_file(start_of_file),
        .total_length (total_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .error_code   (error_code),
        .mip_index    (mip_index),
        .data_offset  (data_offset),
        .data_size    (data_size),
        .mip_width    (mip_width),
        .mip_height   (mip_height),
        .pixel_format (pixel_format),
        .level_count  (level_count),
        .last         (last)
    );

    // Descriptors still owed by the parser, oldest first.
    mip_result_t owed_results[$];
    // Results produced by the predictor for the byte just taken.
    mip_result_t fresh_results[$];

    int failures;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_requests;

    // Predictor state: a copy of what the parser keeps while it reads one file.
    logic [7:0]  hdr_pos;
    logic [31:0] hdr_word;
    logic [31:0] hdr_length;
    logic [31:0] hdr_flags;
    logic [31:0] hdr_width;
    logic [31:0] hdr_height;
    logic [31:0] hdr_mips;
    logic [31:0] hdr_pf_flags;
    logic [31:0] hdr_four_cc;
    logic [31:0] hdr_format;
    logic        file_idle;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic mip_result_t error_result(input dhmp_pkg::err_t code,
                                                 input logic [31:0] fmt);
        mip_result_t r;
        r = '0;
        r.kind   = KIND_ERR;
        r.code   = code;
        r.format = fmt;
        r.last   = 1'b1;
        return r;
    endfunction

    // Exact byte size of one level. Products that do not fit 32 bits saturate at 2^32,
    // which is already larger than any file can be.
    function automatic logic [63:0] level_bytes(input logic [31:0] w, input logic [31:0] h,
                                                input logic [31:0] fmt);
        logic [63:0] unit;
        logic [63:0] p;
        logic [31:0] bx;
        logic [31:0] by;
        bit          blocks;
        blocks = 1'b1;
        case (fmt)
            32'd71, 32'd72, 32'd80, 32'd81: unit = 64'd8;
            32'd74, 32'd75, 32'd77, 32'd78, 32'd83, 32'd84,
            32'd95, 32'd96, 32'd98, 32'd99: unit = 64'd16;
            32'd28, 32'd29:
            begin
                unit = 64'd4;
                blocks = 1'b0;
            end
            32'd10:
            begin
                unit = 64'd8;
                blocks = 1'b0;
            end
            32'd2:
            begin
                unit = 64'd16;
                blocks = 1'b0;
            end
            default: return 64'd0;
        endcase
        if (blocks)
        begin
            bx = (w >> 2) + ((w & 32'd3) != 0);
            by = (h >> 2) + ((h & 32'd3) != 0);
            p = 64'(bx) * 64'(by);
        end
        else
        begin
            p = 64'(w) * 64'(h);
        end
        if (p > 64'hFFFF_FFFF)
            return 64'h1_0000_0000;
        return p * unit;
    endfunction

    // Walks the mip chain once the last DX10 header byte is in. Any error replaces the
    // descriptors gathered so far.
    task automatic walk_chain();
        logic [31:0] count;
        logic [31:0] levels;
        logic [31:0] w;
        logic [31:0] h;
        logic [63:0] offset;
        logic [63:0] size;
        mip_result_t r;
        count = ((hdr_flags & dhmp_pkg::FLAG_MIPCNT) != 0 && hdr_mips != 0) ? hdr_mips : 32'd1;
        levels = (count > LEVEL_LIMIT) ? LEVEL_LIMIT : count;
        w = hdr_width;
        h = hdr_height;
        offset = 64'(dhmp_pkg::DATA_START);
        file_idle = 1'b1;
        for (int lvl = 0; lvl < levels; lvl++)
        begin
            size = level_bytes(w, h, hdr_format);
            if (size == 0)
            begin
                fresh_results.delete();
                fresh_results.push_back(error_result(dhmp_pkg::ERR_FORMAT, hdr_format));
                return;
            end
            if (offset + size > 64'(hdr_length))
            begin
                fresh_results.delete();
                fresh_results.push_back(error_result(dhmp_pkg::ERR_MIP_CUT, hdr_format));
                return;
            end
            r.kind   = KIND_MIP;
            r.code   = dhmp_pkg::ERR_NONE;
            r.index  = 4'(lvl);
            r.offset = offset[31:0];
            r.size   = size[31:0];
            r.width  = w;
            r.height = h;
            r.format = hdr_format;
            r.count  = count[4:0];
            r.last   = (lvl + 1 == levels);
            fresh_results.push_back(r);
            offset = offset + size;
            w = (w > 1) ? (w >> 1) : 32'd1;
            h = (h > 1) ? (h >> 1) : 32'd1;
        end
        if (count > LEVEL_LIMIT)
        begin
            fresh_results.delete();
            fresh_results.push_back(error_result(dhmp_pkg::ERR_TOO_MANY, hdr_format));
        end
    endtask

    // Predicts what one accepted byte causes; results land in fresh_results.
    task automatic predict_byte(input logic [7:0] b, input logic sof, input logic [31:0] len);
        logic [7:0] pos;
        fresh_results.delete();
        if (sof)
        begin
            hdr_pos = '0;
            hdr_word = '0;
            hdr_flags = '0;
            hdr_width = '0;
            hdr_height = '0;
            hdr_mips = '0;
            hdr_pf_flags = '0;
            hdr_four_cc = '0;
            hdr_format = '0;
            file_idle = 1'b0;
            hdr_length = len;
            if (len < dhmp_pkg::HDR_END)
            begin
                file_idle = 1'b1;
                fresh_results.push_back(error_result(dhmp_pkg::ERR_SHORT, '0));
                return;
            end
        end
        else if (file_idle)
        begin
            return;
        end
        pos = hdr_pos;
        hdr_word = (hdr_word >> 8) | (32'(b) << 24);
        hdr_pos = pos + 8'd1;
        case (pos)
            dhmp_pkg::POS_MAGIC:
                if (hdr_word != dhmp_pkg::FILE_MAGIC)
                begin
                    file_idle = 1'b1;
                    fresh_results.push_back(error_result(dhmp_pkg::ERR_MAGIC, '0));
                end
            dhmp_pkg::POS_FLAGS:  hdr_flags = hdr_word;
            dhmp_pkg::POS_HEIGHT: hdr_height = hdr_word;
            dhmp_pkg::POS_WIDTH:  hdr_width = hdr_word;
            dhmp_pkg::POS_MIPS:   hdr_mips = hdr_word;
            dhmp_pkg::POS_PFFLAG: hdr_pf_flags = hdr_word;
            dhmp_pkg::POS_FOURCC: hdr_four_cc = hdr_word;
            dhmp_pkg::POS_HDREND:
            begin
                file_idle = 1'b1;
                if (!((hdr_pf_flags & dhmp_pkg::PF_FOURCC) != 0
                      && hdr_four_cc == dhmp_pkg::FOURCC_DX10))
                    fresh_results.push_back(error_result(dhmp_pkg::ERR_NOT_DX10, '0));
                else if (64'(hdr_length) < 64'(dhmp_pkg::DATA_START))
                    fresh_results.push_back(error_result(dhmp_pkg::ERR_DX10_CUT, '0));
                else
                    file_idle = 1'b0;
            end
            dhmp_pkg::POS_FORMAT: hdr_format = hdr_word;
            dhmp_pkg::POS_LAST:   walk_chain();
            default: ;
        endcase
    endtask

    // Offers one byte transaction and waits until it is taken. Entered and left at a
    // falling edge, so the inputs only ever change there.
    task automatic send_byte(input logic [7:0] b, input logic sof, input logic [31:0] len,
                             input bit typed, input dhmp_pkg::err_t typed_code);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        data_byte = b;
        start_of_file = sof;
        total_length = len;
        do
            @(posedge clk);
        while (!in_ready);
        predict_byte(b, sof, len);
        foreach (fresh_results[i])
        begin
            if (typed)
                owed_results.push_back(error_result(typed_code, '0));
            else
                owed_results.push_back(fresh_results[i]);
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_file(input dds_file_t f);
        logic [7:0] image [HDR_BYTES];
        foreach (image[i])
            image[i] = 8'($urandom);
        for (int i = 0; i < 4; i++)
        begin
            image[i]       = f.magic[8*i +: 8];
            image[4 + i]   = (i == 0) ? 8'd124 : 8'd0;
            image[8 + i]   = f.flags[8*i +: 8];
            image[12 + i]  = f.height[8*i +: 8];
            image[16 + i]  = f.width[8*i +: 8];
            image[28 + i]  = f.mips[8*i +: 8];
            image[80 + i]  = f.pf_flags[8*i +: 8];
            image[84 + i]  = f.four_cc[8*i +: 8];
            image[128 + i] = f.format[8*i +: 8];
        end
        if (f.hold)
            hold_requests++;
        for (int i = 0; i < f.nbytes; i++)
            send_byte(image[i], i == 0, f.length, f.typed, f.typed_code);
        // Stray bytes with no start must be ignored by an idle parser.
        for (int i = 0; i < f.tail; i++)
            send_byte(8'($urandom), 1'b0, $urandom, 1'b0, dhmp_pkg::ERR_NONE);
    endtask

    // A well-formed DX10 file; the directed rows and the random part adjust it.
    function automatic dds_file_t good_file(input logic [31:0] fmt, input logic [31:0] w,
                                            input logic [31:0] h, input logic [31:0] mips,
                                            input logic [31:0] len);
        dds_file_t f;
        f.length = len;
        f.magic = dhmp_pkg::FILE_MAGIC;
        f.flags = dhmp_pkg::FLAG_MIPCNT | 32'h0000_1007;
        f.width = w;
        f.height = h;
        f.mips = mips;
        f.pf_flags = dhmp_pkg::PF_FOURCC;
        f.four_cc = dhmp_pkg::FOURCC_DX10;
        f.format = fmt;
        f.nbytes = HDR_BYTES;
        f.tail = 0;
        f.typed = 1'b0;
        f.typed_code = dhmp_pkg::ERR_NONE;
        f.hold = 1'b0;
        return f;
    endfunction

    function automatic dds_file_t typed_file(input dds_file_t f, input dhmp_pkg::err_t code,
                                             input int nbytes);
        f.typed = 1'b1;
        f.typed_code = code;
        f.nbytes = nbytes;
        return f;
    endfunction

    function automatic dds_file_t random_file();
        dds_file_t f;
        logic [31:0] fmt_pool [17];
        int pick;
        fmt_pool = '{32'd71, 32'd72, 32'd80, 32'd81, 32'd74, 32'd75, 32'd77, 32'd78,
                     32'd83, 32'd84, 32'd95, 32'd96, 32'd98, 32'd99, 32'd28, 32'd29,
                     32'd10};
        pick = $urandom_range(0, 99);
        f = good_file(($urandom_range(0, 17) == 17) ? FMT_RGBA32F
                                                    : fmt_pool[$urandom_range(0, 16)],
                      $urandom_range(0, 40), $urandom_range(0, 40),
                      $urandom_range(0, 18), 32'd148 + $urandom_range(0, 3000));
        f.flags = $urandom | dhmp_pkg::FLAG_MIPCNT;
        f.pf_flags = $urandom | dhmp_pkg::PF_FOURCC;
        f.tail = $urandom_range(0, 3);
        if (pick < 25)
        begin
            f.length = $urandom_range(0, 127);
            f.nbytes = 1;
        end
        else if (pick < 35)
        begin
            f.magic = $urandom;
            f.length = $urandom;
            f.nbytes = 4;
        end
        else if (pick < 42)
        begin
            if ($urandom_range(0, 1))
                f.four_cc = $urandom;
            else
                f.pf_flags = $urandom & ~dhmp_pkg::PF_FOURCC;
            f.nbytes = 128;
        end
        else if (pick < 45)
        begin
            f.length = $urandom_range(128, 147);
            f.nbytes = 128;
        end
        else
        begin
            // Well-formed files with random content; a few are cut short by a restart.
            if ($urandom_range(0, 9) == 0)
                f.format = $urandom;
            if ($urandom_range(0, 7) == 0)
                f.width = $urandom;
            if ($urandom_range(0, 7) == 0)
                f.height = $urandom;
            if ($urandom_range(0, 9) == 0)
                f.mips = $urandom;
            if ($urandom_range(0, 4) == 0)
                f.flags = $urandom & ~dhmp_pkg::FLAG_MIPCNT;
            case ($urandom_range(0, 4))
                0: f.length = $urandom;
                1: f.length = 32'hFFFF_FFFF;
                default: ;
            endcase
            if ($urandom_range(0, 12) == 0)
                f.nbytes = $urandom_range(5, HDR_BYTES - 1);
        end
        return f;
    endfunction

    // Holds all inputs until every owed result has come back.
    task automatic drain();
        while (owed_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request while the sender goes on.
    initial
    begin : receiver
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
            begin
                out_ready = ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // Compares every result transaction with the oldest owed descriptor.
    always @(posedge clk)
    begin
        mip_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result, expected none, got kind %0b code %0d",
                         $time, kind, error_code);
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("error_code", 32'(want.code), 32'(error_code));
                check_field("mip_index", 32'(want.index), 32'(mip_index));
                check_field("data_offset", want.offset, data_offset);
                check_field("data_size", want.size, data_size);
                check_field("mip_width", want.width, mip_width);
                check_field("mip_height", want.height, mip_height);
                check_field("pixel_format", want.format, pixel_format);
                check_field("level_count", 32'(want.count), 32'(level_count));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG)
            begin
                $display("dds_header_mip_chain_parser_test NOT OK");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        dds_file_t directed [$];
        dds_file_t f;
        int files;
        failures = 0;
        hold_requests = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        file_idle = 1'b1;
        hdr_pos = '0;
        in_valid = 1'b0;
        data_byte = '0;
        start_of_file = 1'b0;
        total_length = '0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Bytes straight after reset, with no start, are ignored.
        f = good_file(FMT_BC1, 32'd4, 32'd4, 32'd1, 32'd200);
        f.nbytes = 0;
        f.tail = 3;
        directed.push_back(f);
        // Length checks on the start byte: zero and one below a full header.
        directed.push_back(typed_file(good_file(FMT_BC1, 4, 4, 1, 32'd0),
                                      dhmp_pkg::ERR_SHORT, 1));
        directed.push_back(typed_file(good_file(FMT_BC1, 4, 4, 1, 32'd127),
                                      dhmp_pkg::ERR_SHORT, 1));
        f = good_file(FMT_BC1, 4, 4, 1, 32'hFFFF_FFFF);
        f.magic = ~dhmp_pkg::FILE_MAGIC;
        directed.push_back(typed_file(f, dhmp_pkg::ERR_MAGIC, 4));
        f = good_file(FMT_BC1, 4, 4, 1, 32'd300);
        f.four_cc = 32'h3154_5844;
        directed.push_back(typed_file(f, dhmp_pkg::ERR_NOT_DX10, 128));
        f = good_file(FMT_BC1, 4, 4, 1, 32'd300);
        f.pf_flags = 32'hFFFF_FFFB;
        directed.push_back(typed_file(f, dhmp_pkg::ERR_NOT_DX10, 128));
        // The DX10 header is cut: the smallest and largest such lengths.
        directed.push_back(typed_file(good_file(FMT_BC1, 4, 4, 1, 32'd128),
                                      dhmp_pkg::ERR_DX10_CUT, 128));
        directed.push_back(typed_file(good_file(FMT_BC1, 4, 4, 1, 32'd147),
                                      dhmp_pkg::ERR_DX10_CUT, 128));
        // Unknown format, and a zero dimension with a known one.
        directed.push_back(good_file(FMT_UNKNOWN, 8, 8, 1, 32'd1000));
        directed.push_back(good_file(FMT_RGBA8, 0, 8, 1, 32'd1000));
        // The first level just fits, then misses by one byte.
        directed.push_back(good_file(FMT_BC1, 4, 4, 1, 32'd156));
        directed.push_back(good_file(FMT_BC1, 4, 4, 1, 32'd155));
        // Mip-count flag clear, and set with a count of zero: one level either way.
        f = good_file(FMT_BC3, 16, 8, 9, 32'd2000);
        f.flags = 32'h0000_1007;
        directed.push_back(f);
        directed.push_back(good_file(FMT_RGBA16F, 5, 3, 0, 32'd2000));
        // Sixteen levels while the receiver is held off, so the parser backs up.
        f = good_file(FMT_RGBA32F, 32'd40000, 32'd3, 32'd16, 32'hFFFF_FFFF);
        f.hold = 1'b1;
        f.tail = 2;
        directed.push_back(f);
        // One level too many, and the largest count.
        directed.push_back(good_file(FMT_BC1, 1024, 1024, 17, 32'hFFFF_FFFF));
        directed.push_back(good_file(FMT_BC1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Widest dimensions: the size no longer fits 32 bits.
        directed.push_back(good_file(FMT_RGBA32F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                                     32'hFFFF_FFFF));
        directed.push_back(good_file(FMT_RGBA8, 32'hFFFF_FFFF, 1, 2, 32'hFFFF_FFFF));
        // A restart in the middle of a header abandons that file.
        f = good_file(FMT_BC1, 8, 8, 3, 32'd1000);
        f.nbytes = 60;
        directed.push_back(f);
        directed.push_back(good_file(FMT_BC1, 8, 8, 3, 32'd1000));

        foreach (directed[i])
            send_file(directed[i]);
        drain();

        // Random files, the idling pattern changing every phase; between phases the
        // sender pauses until every owed result is back.
        files = 0;
        while (files < 32)
        begin
            case ((files / 8) % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 74;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 74;
                end
                default:
                begin
                    sender_idle_pct = 17;
                    receiver_stall_pct = 17;
                end
            endcase
            send_file(random_file());
            files++;
            if (files % 8 == 0)
                drain();
        end

        drain();
        repeat (200) @(negedge clk);
        if (failures == 0 && owed_results.size() == 0)
            $display("dds_header_mip_chain_parser_test OK");
        else
            $display("dds_header_mip_chain_parser_test NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
